### design/axis_angle_rotation_matrix_unit_macros.svh
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix unit - assertion macros
// Concurrent check shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_MACROS_SVH

// same-cycle implication
`define AARM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AARM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Types and constants shared by the axis-angle rotation matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aarm_pkg;

  localparam int SINCOS_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int CW  = 34;  // cordic x/y datapath
  localparam int ZW  = 32;  // angle accumulator, 2^32 per turn
  localparam int SCW = 32;  // sin/cos handed to the matrix stages, Q2.30

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [ZW-1:0] ATAN_TURN32 [0:ATAN_ENTRIES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic        [15:0] turn_angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

  typedef struct packed {
    logic signed [SCW-1:0] c;
    logic signed [SCW-1:0] s;
    axis_t                 axis;
  } rot_t;

  typedef struct packed {
    logic signed [15:0] entry_0_0;
    logic signed [15:0] entry_0_1;
    logic signed [15:0] entry_0_2;
    logic signed [15:0] entry_1_0;
    logic signed [15:0] entry_1_1;
    logic signed [15:0] entry_1_2;
    logic signed [15:0] entry_2_0;
    logic signed [15:0] entry_2_1;
    logic signed [15:0] entry_2_2;
  } out_t;

endpackage

`default_nettype wire

### design/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic
// Pipelined rotation-mode CORDIC: quadrant split, one micro-rotation per
// register stage, quadrant fold-back. The axis rides along with the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_cordic #(
  parameter int STAGES = aarm_pkg::SINCOS_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire aarm_pkg::in_t in_beat,
  output logic               out_v,
  output aarm_pkg::rot_t     out_rot
);

  localparam int NST = (STAGES < 1) ? 1 :
                       ((STAGES > aarm_pkg::ATAN_ENTRIES) ? aarm_pkg::ATAN_ENTRIES : STAGES);
  localparam int CW  = aarm_pkg::CW;
  localparam int ZW  = aarm_pkg::ZW;
  localparam int SCW = aarm_pkg::SCW;

  logic                    v_r    [0:NST];
  logic signed [CW-1:0]    x_r    [0:NST];
  logic signed [CW-1:0]    y_r    [0:NST];
  logic signed [ZW-1:0]    z_r    [0:NST];
  aarm_pkg::quad_t         quad_r [0:NST];
  aarm_pkg::axis_t         axis_r [0:NST];

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= aarm_pkg::CORDIC_X0;
      y_r[0]    <= '0;
      z_r[0]    <= $signed({2'b00, in_beat.turn_angle[13:0], 16'h0000});
      quad_r[0] <= aarm_pkg::quad_t'(in_beat.turn_angle[15:14]);
      axis_r[0] <= '{x: in_beat.axis_x, y: in_beat.axis_y, z: in_beat.axis_z};
    end
  end

  // micro-rotations
  for (genvar i = 0; i < NST; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = $signed(aarm_pkg::ATAN_TURN32[i]);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] x_nxt;
    logic signed [CW-1:0] y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (!z_r[i][ZW-1]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - ATAN;
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        quad_r[i+1] <= quad_r[i];
        axis_r[i+1] <= axis_r[i];
      end
    end
  end

  // quadrant fold-back
  logic signed [CW-1:0] c_nxt;
  logic signed [CW-1:0] s_nxt;
  logic                 out_v_r;
  aarm_pkg::rot_t       out_rot_r;

  always_comb begin
    case (quad_r[NST])
      aarm_pkg::QUAD_II: begin
        c_nxt = -y_r[NST];
        s_nxt = x_r[NST];
      end
      aarm_pkg::QUAD_III: begin
        c_nxt = -x_r[NST];
        s_nxt = -y_r[NST];
      end
      aarm_pkg::QUAD_IV: begin
        c_nxt = y_r[NST];
        s_nxt = -x_r[NST];
      end
      default: begin
        c_nxt = x_r[NST];
        s_nxt = y_r[NST];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot_r.c    <= c_nxt[SCW-1:0];
      out_rot_r.s    <= s_nxt[SCW-1:0];
      out_rot_r.axis <= axis_r[NST];
    end
  end

  assign out_v   = out_v_r;
  assign out_rot = out_rot_r;

endmodule

`default_nettype wire

### design/aarm_matrix.sv
// ----------------------------------------------------------------------------
// aarm_matrix
// Rodrigues matrix assembly: axis products, split (1-c) partial products,
// exact wide accumulation, then round to Q2.14 and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_matrix (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_v,
  input  wire aarm_pkg::rot_t in_rot,
  output logic                out_v,
  output aarm_pkg::out_t      out_beat
);

  localparam int SCW = aarm_pkg::SCW;
  localparam int OW  = SCW + 1;   // 1 - c
  localparam int PW  = 32;        // axis products
  localparam int HW  = 49;        // split partial products
  localparam int TW  = 48;        // s * axis
  localparam int AW  = 64;        // accumulator

  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int NP   = 6;

  localparam logic signed [OW-1:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [AW-1:0] RND_HALF = 64'sd8796093022208;

  function automatic logic signed [15:0] rnd_sat(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] t;
    logic signed [19:0]   r;
    t = acc + RND_HALF;
    r = t[AW-1:44];
    if (r > 20'sd32767) begin
      return 16'sh7fff;
    end else if (r < -20'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  // stage A: 1 - c and axis products
  logic                   va_r;
  logic signed [OW-1:0]   omc_a_r;
  logic signed [SCW-1:0]  c_a_r;
  logic signed [SCW-1:0]  s_a_r;
  aarm_pkg::axis_t        axis_a_r;
  logic signed [PW-1:0]   prod_a_r [0:NP-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      omc_a_r        <= ONE_Q30 - OW'(in_rot.c);
      c_a_r          <= in_rot.c;
      s_a_r          <= in_rot.s;
      axis_a_r       <= in_rot.axis;
      prod_a_r[P_XX] <= in_rot.axis.x * in_rot.axis.x;
      prod_a_r[P_YY] <= in_rot.axis.y * in_rot.axis.y;
      prod_a_r[P_ZZ] <= in_rot.axis.z * in_rot.axis.z;
      prod_a_r[P_XY] <= in_rot.axis.x * in_rot.axis.y;
      prod_a_r[P_XZ] <= in_rot.axis.x * in_rot.axis.z;
      prod_a_r[P_YZ] <= in_rot.axis.y * in_rot.axis.z;
    end
  end

  // stage B: (1-c) split in high and low halves, s times axis
  logic                  vb_r;
  logic signed [SCW-1:0] c_b_r;
  logic signed [HW-1:0]  ph_b_r [0:NP-1];
  logic signed [HW-1:0]  pl_b_r [0:NP-1];
  logic signed [TW-1:0]  sx_b_r;
  logic signed [TW-1:0]  sy_b_r;
  logic signed [TW-1:0]  sz_b_r;
  logic signed [16:0]    omc_hi;
  logic signed [16:0]    omc_lo;
  logic signed [HW-1:0]  ph_nxt [0:NP-1];
  logic signed [HW-1:0]  pl_nxt [0:NP-1];

  always_comb begin
    omc_hi = omc_a_r[OW-1:16];
    omc_lo = $signed({1'b0, omc_a_r[15:0]});
    for (int k = 0; k < NP; k++) begin
      ph_nxt[k] = HW'(omc_hi) * HW'(prod_a_r[k]);
      pl_nxt[k] = HW'(omc_lo) * HW'(prod_a_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_b_r  <= c_a_r;
      ph_b_r <= ph_nxt;
      pl_b_r <= pl_nxt;
      sx_b_r <= TW'(s_a_r) * TW'(axis_a_r.x);
      sy_b_r <= TW'(s_a_r) * TW'(axis_a_r.y);
      sz_b_r <= TW'(s_a_r) * TW'(axis_a_r.z);
    end
  end

  // stage C: exact Q.58 entries
  logic                 vc_r;
  logic signed [AW-1:0] acc_c_r [0:8];
  logic signed [AW-1:0] omcp    [0:NP-1];
  logic signed [AW-1:0] cd;
  logic signed [AW-1:0] tx;
  logic signed [AW-1:0] ty;
  logic signed [AW-1:0] tz;
  logic signed [AW-1:0] acc_nxt [0:8];

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      omcp[k] = (AW'(ph_b_r[k]) <<< 16) + AW'(pl_b_r[k]);
    end
    cd = AW'(c_b_r) <<< 28;
    tx = AW'(sx_b_r) <<< 14;
    ty = AW'(sy_b_r) <<< 14;
    tz = AW'(sz_b_r) <<< 14;
    acc_nxt[0] = cd + omcp[P_XX];
    acc_nxt[1] = omcp[P_XY] - tz;
    acc_nxt[2] = omcp[P_XZ] + ty;
    acc_nxt[3] = omcp[P_XY] + tz;
    acc_nxt[4] = cd + omcp[P_YY];
    acc_nxt[5] = omcp[P_YZ] - tx;
    acc_nxt[6] = omcp[P_XZ] - ty;
    acc_nxt[7] = omcp[P_YZ] + tx;
    acc_nxt[8] = cd + omcp[P_ZZ];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_c_r <= acc_nxt;
    end
  end

  // stage D: round and saturate
  logic           vd_r;
  aarm_pkg::out_t beat_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_d_r.entry_0_0 <= rnd_sat(acc_c_r[0]);
      beat_d_r.entry_0_1 <= rnd_sat(acc_c_r[1]);
      beat_d_r.entry_0_2 <= rnd_sat(acc_c_r[2]);
      beat_d_r.entry_1_0 <= rnd_sat(acc_c_r[3]);
      beat_d_r.entry_1_1 <= rnd_sat(acc_c_r[4]);
      beat_d_r.entry_1_2 <= rnd_sat(acc_c_r[5]);
      beat_d_r.entry_2_0 <= rnd_sat(acc_c_r[6]);
      beat_d_r.entry_2_1 <= rnd_sat(acc_c_r[7]);
      beat_d_r.entry_2_2 <= rnd_sat(acc_c_r[8]);
    end
  end

  assign out_v    = vd_r;
  assign out_beat = beat_d_r;

endmodule

`default_nettype wire

### design/axis_angle_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit
// 3x3 rotation matrix from a binary angle and a Q2.14 axis (Rodrigues).
//
//   channel | direction | payload          | handshake
//   in_     | input     | aarm_pkg::in_t   | in_valid / in_stall
//   out_    | output    | aarm_pkg::out_t  | out_valid / out_stall
//
// One beat per cycle sustained while in_stall is low.
// Depth is set by the CORDIC chain, one micro-rotation per stage, plus four
// matrix stages and the output register.
// rst_n clears all valid bits; payload registers are not reset.
// A beat that arrives while the output is stalled parks in a skid register;
// in_stall is that skid register's full flag, so the pipe freezes only then.
// ----------------------------------------------------------------------------
`default_nettype none

`include "axis_angle_rotation_matrix_unit_macros.svh"

module axis_angle_rotation_matrix_unit #(
  parameter int SINCOS_STAGES = aarm_pkg::SINCOS_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire aarm_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output aarm_pkg::out_t     out_data
);

  logic           pipe_en;
  logic           rot_v;
  aarm_pkg::rot_t rot;
  logic           m_v;
  aarm_pkg::out_t m_beat;
  logic           arrive;

  logic           out_v_r;
  logic           out_v_nxt;
  aarm_pkg::out_t out_data_r;
  logic           skid_v_r;
  logic           skid_v_nxt;
  aarm_pkg::out_t skid_data_r;

  assign pipe_en = !skid_v_r;
  assign arrive  = m_v && pipe_en;

  aarm_cordic #(
    .STAGES (SINCOS_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_v    (in_valid),
    .in_beat (in_data),
    .out_v   (rot_v),
    .out_rot (rot)
  );

  aarm_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_v     (rot_v),
    .in_rot   (rot),
    .out_v    (m_v),
    .out_beat (m_beat)
  );

  // output register with skid
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || !out_stall) begin
      out_v_nxt  = skid_v_r || arrive;
      skid_v_nxt = 1'b0;
    end else if (arrive) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_data_r <= skid_v_r ? skid_data_r : m_beat;
    end
    if (out_v_r && out_stall && !skid_v_r) begin
      skid_data_r <= m_beat;
    end
  end

  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  `AARM_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r, "skid holds a beat with output empty")
  `AARM_ASSERT_NEXT(a_skid_drains, out_v_r && !out_stall && skid_v_r, !skid_v_r, "skid not drained")
  `AARM_ASSERT_NEXT(a_beat_parks, out_v_r && out_stall && !skid_v_r && m_v, skid_v_r, "beat lost")

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix unit testbench
// Drives angle/axis beats through a queue-fed driver with random gaps, stalls
// the result channel in random bursts, and checks all nine matrix entries of
// every result beat against a fixed-point Rodrigues/CORDIC predictor.
// ----------------------------------------------------------------------------
module testbench;
  import aarm_pkg::*;

  localparam int SINCOS_STAGES  = 16;
  localparam int CORDIC_STEPS   = (SINCOS_STAGES < 1) ? 1 :
                                  (SINCOS_STAGES > 24) ? 24 : SINCOS_STAGES;
  localparam int PIPE_LATENCY   = SINCOS_STAGES + 7;
  localparam int RANDOM_ITEMS   = 380;
  localparam int CALM_TAIL      = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint GAIN_X0    = 652032874;

  typedef struct {
    in_t data;
    bit  drain;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  request_t requests_pending[$];
  out_t     matrix_due[$];
  int       total_items = 0;
  int       sent = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       calm = 1'b0;
  int       mismatches = 0;
  int       beats_out = 0;
  int       quiet = 0;

  longint atan_q32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  string entry_name [9] = '{
    "entry_0_0", "entry_0_1", "entry_0_2", "entry_1_0", "entry_1_1",
    "entry_1_2", "entry_2_0", "entry_2_1", "entry_2_2"
  };

  axis_angle_rotation_matrix_unit #(.SINCOS_STAGES(SINCOS_STAGES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sin/cos in Q2.30 from the quarter-turn remainder, then quadrant swap
  function automatic void cordic_sincos(input logic [15:0] ang, output longint cosv,
                                        output longint sinv);
    quad_t  quad;
    longint xr, yr, zr, dx, dy, t;
    quad = quad_t'(ang[15:14]);
    zr = longint'(ang[13:0]) * 65536;
    xr = GAIN_X0;
    yr = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (zr >= 0) begin
        xr = xr - dx; yr = yr + dy; zr = zr - atan_q32[i];
      end else begin
        xr = xr + dx; yr = yr - dy; zr = zr + atan_q32[i];
      end
    end
    case (quad)
      QUAD_II: begin
        t = xr; xr = -yr; yr = t;
      end
      QUAD_III: begin
        xr = -xr; yr = -yr;
      end
      QUAD_IV: begin
        t = xr; xr = yr; yr = -t;
      end
      default: ;
    endcase
    cosv = xr;
    sinv = yr;
  endfunction

  function automatic logic signed [15:0] round_q14(input longint acc);
    longint r;
    r = (acc + (longint'(1) << 43)) >>> 44;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic out_t rodrigues_matrix(input in_t req);
    out_t   m;
    longint c, s, omc, cd, ax, ay, az, sc;
    cordic_sincos(req.turn_angle, c, s);
    ax = longint'(req.axis_x);
    ay = longint'(req.axis_y);
    az = longint'(req.axis_z);
    omc = (longint'(1) << 30) - c;
    cd = c * (longint'(1) << 28);
    sc = longint'(1) << 14;
    m.entry_0_0 = round_q14(cd + omc * (ax * ax));
    m.entry_0_1 = round_q14(omc * (ax * ay) - s * az * sc);
    m.entry_0_2 = round_q14(omc * (ax * az) + s * ay * sc);
    m.entry_1_0 = round_q14(omc * (ay * ax) + s * az * sc);
    m.entry_1_1 = round_q14(cd + omc * (ay * ay));
    m.entry_1_2 = round_q14(omc * (ay * az) - s * ax * sc);
    m.entry_2_0 = round_q14(omc * (az * ax) - s * ay * sc);
    m.entry_2_1 = round_q14(omc * (az * ay) + s * ax * sc);
    m.entry_2_2 = round_q14(cd + omc * (az * az));
    return m;
  endfunction

  function automatic void add_request(input logic [15:0] ang, input int vx, input int vy,
                                      input int vz, input bit drain);
    request_t r;
    r.data.turn_angle = ang;
    r.data.axis_x = 16'(vx);
    r.data.axis_y = 16'(vy);
    r.data.axis_z = 16'(vz);
    r.drain = drain;
    requests_pending.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) matrix_due.push_back(rodrigues_matrix(in_data));
      calm = (sent + CALM_TAIL >= total_items);
      case ((sent / 50) % 3)
        0: begin idle_pct = 15; stall_pct = 20; end
        1: begin idle_pct = 0;  stall_pct = 0;  end
        default: begin idle_pct = 40; stall_pct = 50; end
      endcase
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_pending.size() != 0 &&
                   !(requests_pending[0].drain && matrix_due.size() != 0)) begin
        in_valid <= 1'b1;
        in_data  <= requests_pending[0].data;
        void'(requests_pending.pop_front());
        sent++;
        if (!calm && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_t             want;
    logic [143:0]     wv, gv;
    logic signed [15:0] we, ge;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (matrix_due.size() == 0) begin
          if (mismatches < 10) $display("beat %0d: result with nothing expected", beats_out);
          mismatches++;
        end else begin
          want = matrix_due.pop_front();
          wv = want;
          gv = out_data;
          for (int k = 0; k < 9; k++) begin
            we = wv[143 - 16*k -: 16];
            ge = gv[143 - 16*k -: 16];
            if (we !== ge) begin
              if (mismatches < 10)
                $display("beat %0d %s: expected %0d got %0d", beats_out, entry_name[k], we, ge);
              mismatches++;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    real         vx, vy, vz, norm;
    int          pick, sel, ix, iy, iz;
    logic [15:0] ang;

    // quadrants, boundaries and the identity on principal axes
    add_request(16'h0000, 16384, 0, 0, 1'b0);
    add_request(16'h4000, 16384, 0, 0, 1'b0);
    add_request(16'h8000, 0, 16384, 0, 1'b0);
    add_request(16'hC000, 0, 0, 16384, 1'b0);
    add_request(16'hFFFF, -16384, 0, 0, 1'b0);
    add_request(16'h3FFF, 0, -16384, 0, 1'b0);
    add_request(16'h0001, 0, 0, -16384, 1'b0);
    add_request(16'h2000, 9459, 9459, 9459, 1'b0);
    add_request(16'h7FFF, -9459, 9459, -9459, 1'b0);
    add_request(16'hBFFF, 11585, 0, -11585, 1'b0);
    add_request(16'h4001, 0, 11585, 11585, 1'b0);
    // non-unit and out-of-range axes, saturating entries
    add_request(16'h8000, 32767, 32767, 32767, 1'b0);
    add_request(16'h8000, -32768, -32768, -32768, 1'b0);
    add_request(16'h4000, -32768, 32767, 0, 1'b0);
    add_request(16'hC000, 32767, -32768, -32768, 1'b0);
    add_request(16'h0000, -32768, -32768, -32768, 1'b0);
    add_request(16'h2000, 32767, -32768, 32767, 1'b0);
    add_request(16'hE000, 0, 0, 0, 1'b0);
    add_request(16'h5555, 16385, -16385, 20000, 1'b0);
    add_request(16'hAAAA, 1, -1, 0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0)
        ang = {2'($urandom_range(0, 3)), ($urandom_range(0, 1) ? 14'h3FFF : 14'h0000)};
      else
        ang = 16'($urandom_range(0, 65535));
      if (pick < 55) begin
        vx = real'($urandom_range(0, 65535)) - 32768.0;
        vy = real'($urandom_range(0, 65535)) - 32768.0;
        vz = real'($urandom_range(0, 65535)) - 32768.0;
        norm = $sqrt(vx * vx + vy * vy + vz * vz);
        if (norm < 1.0) begin
          vx = 1.0;
          norm = 1.0;
        end
        ix = $rtoi(vx * 16384.0 / norm);
        iy = $rtoi(vy * 16384.0 / norm);
        iz = $rtoi(vz * 16384.0 / norm);
      end else if (pick < 70) begin
        sel = $urandom_range(0, 2);
        ix = (sel == 0) ? ($urandom_range(0, 1) ? 16384 : -16384) : 0;
        iy = (sel == 1) ? ($urandom_range(0, 1) ? 16384 : -16384) : 0;
        iz = (sel == 2) ? ($urandom_range(0, 1) ? 16384 : -16384) : 0;
      end else begin
        ix = $urandom_range(0, 65535);
        iy = $urandom_range(0, 65535);
        iz = $urandom_range(0, 65535);
      end
      add_request(ang, ix, iy, iz, (n == 0) || (n == 190));
    end
    total_items = requests_pending.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_pending.size() != 0 || in_valid || matrix_due.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (mismatches == 0 && matrix_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
